FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, masked while reset is high
`define SMSDD_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked through reset as well
`define SMSDD_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/smsdd_pkg.sv
package smsdd_pkg;

   localparam int unsigned MaxResults = 4;

   localparam logic [7:0] UDHI_MASK   = 8'h40;
   localparam logic [7:0] DCS_UCS2    = 8'h08;
   localparam logic [7:0] IEI_CONCAT  = 8'h00;
   localparam logic [7:0] IEL_CONCAT  = 8'h03;
   localparam logic [7:0] UDHL_CONCAT = 8'd5;
   localparam logic [7:0] TS_OCTETS   = 8'd7;
   localparam logic [3:0] NIB_FILL    = 4'hF;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] SEPT_MASK   = 8'h7F;
   localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
   localparam logic [7:0] UTF8_CONT   = 8'h80;
   localparam logic [5:0] UTF8_MASK   = 6'h3F;

   typedef enum logic [3:0] {
      PH_SMSC_LEN  = 4'd0,
      PH_SMSC_SKIP = 4'd1,
      PH_FIRST     = 4'd2,
      PH_ADDR_LEN  = 4'd3,
      PH_TOA       = 4'd4,
      PH_ADDR      = 4'd5,
      PH_PID       = 4'd6,
      PH_DCS       = 4'd7,
      PH_TS        = 4'd8,
      PH_UDL       = 4'd9,
      PH_UDHL      = 4'd10,
      PH_UDH       = 4'd11,
      PH_UCS2      = 4'd12,
      PH_GSM7      = 4'd13,
      PH_DONE      = 4'd14
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SENDER = 2'd0,
      KIND_TIME   = 2'd1,
      KIND_TEXT   = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  field_count;
      logic        udhi_flag;
      logic [7:0]  digits_left;
      logic        coding_ucs2;
      logic [7:0]  septets_left;
      logic [7:0]  header_skip;
      logic        concat_cand;
      logic [7:0]  concat_ref;
      logic [7:0]  concat_total;
      logic [7:0]  concat_seq;
      logic [15:0] bit_buffer;
      logic [3:0]  bit_count;
      logic        ucs2_half;
      logic [7:0]  ucs2_high;
   } state_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
      logic       multipart;
      logic [7:0] concat_ref;
      logic [7:0] concat_total;
      logic [7:0] concat_seq;
      logic       error;
      logic       final_res;
   } result_type;

   typedef struct packed {
      logic [$clog2(MaxResults+1)-1:0]  count;
      result_type [MaxResults-1:0]      res;
   } batch_type;

   function automatic result_type mk_res(kind_type k, logic [7:0] v);
      result_type r;
      r = '0;
      r.kind = k;
      r.value = v;
      return r;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'd0, nib};
      end else begin
         c = CHAR_A + {4'd0, nib} - 8'd10;
      end
      return c;
   endfunction

endpackage

FILE: hw/rtl/smsdd_step.sv
module smsdd_step (
   input  smsdd_pkg::state_type st,
   input  logic [7:0]           octet,
   input  logic                 last,
   output smsdd_pkg::state_type st_in,
   output smsdd_pkg::batch_type batch
);

   always_comb begin
      smsdd_pkg::state_type  s;
      smsdd_pkg::result_type [smsdd_pkg::MaxResults-1:0] r;
      smsdd_pkg::result_type sum;
      logic [2:0]  n;
      logic [3:0]  nib;
      logic [15:0] cp;
      logic [15:0] bbuf;
      logic [3:0]  bc;
      logic        err;
      logic        multi;

      s = st;
      r = '0;
      n = 3'd0;
      nib = 4'd0;
      cp = 16'd0;
      bbuf = 16'd0;
      bc = 4'd0;
      err = 1'b0;
      multi = 1'b0;
      sum = '0;

      case (st.phase)
         smsdd_pkg::PH_SMSC_LEN: begin
            s.field_count = octet;
            s.phase = (octet != 8'd0) ? smsdd_pkg::PH_SMSC_SKIP : smsdd_pkg::PH_FIRST;
         end
         smsdd_pkg::PH_SMSC_SKIP: begin
            s.field_count = st.field_count - 8'd1;
            if (s.field_count == 8'd0) s.phase = smsdd_pkg::PH_FIRST;
         end
         smsdd_pkg::PH_FIRST: begin
            s.udhi_flag = |(octet & smsdd_pkg::UDHI_MASK);
            s.phase = smsdd_pkg::PH_ADDR_LEN;
         end
         smsdd_pkg::PH_ADDR_LEN: begin
            s.digits_left = octet;
            s.field_count = 8'(({1'b0, octet} + 9'd1) >> 1);
            r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_SENDER, smsdd_pkg::CHAR_PLUS);
            n = n + 3'd1;
            s.phase = smsdd_pkg::PH_TOA;
         end
         smsdd_pkg::PH_TOA: begin
            s.phase = (st.field_count != 8'd0) ? smsdd_pkg::PH_ADDR : smsdd_pkg::PH_PID;
         end
         smsdd_pkg::PH_ADDR: begin
            nib = octet[3:0];
            if (nib != smsdd_pkg::NIB_FILL && s.digits_left != 8'd0) begin
               s.digits_left = s.digits_left - 8'd1;
               r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_SENDER, smsdd_pkg::hex_char(nib));
               n = n + 3'd1;
            end
            nib = octet[7:4];
            if (nib != smsdd_pkg::NIB_FILL && s.digits_left != 8'd0) begin
               s.digits_left = s.digits_left - 8'd1;
               r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_SENDER, smsdd_pkg::hex_char(nib));
               n = n + 3'd1;
            end
            s.field_count = st.field_count - 8'd1;
            if (s.field_count == 8'd0) s.phase = smsdd_pkg::PH_PID;
         end
         smsdd_pkg::PH_PID: begin
            s.phase = smsdd_pkg::PH_DCS;
         end
         smsdd_pkg::PH_DCS: begin
            s.coding_ucs2 = (octet == smsdd_pkg::DCS_UCS2);
            s.field_count = smsdd_pkg::TS_OCTETS;
            s.phase = smsdd_pkg::PH_TS;
         end
         smsdd_pkg::PH_TS: begin
            r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_TIME, octet);
            n = n + 3'd1;
            s.field_count = st.field_count - 8'd1;
            if (s.field_count == 8'd0) s.phase = smsdd_pkg::PH_UDL;
         end
         smsdd_pkg::PH_UDL: begin
            s.septets_left = octet;
            if (st.coding_ucs2) begin
               s.phase = st.udhi_flag ? smsdd_pkg::PH_UDHL : smsdd_pkg::PH_UCS2;
            end else begin
               s.phase = (octet != 8'd0) ? smsdd_pkg::PH_GSM7 : smsdd_pkg::PH_DONE;
            end
         end
         smsdd_pkg::PH_UDHL: begin
            s.header_skip = octet;
            s.field_count = 8'd0;
            s.concat_cand = (octet >= smsdd_pkg::UDHL_CONCAT);
            s.concat_ref = 8'd0;
            s.concat_total = 8'd0;
            s.concat_seq = 8'd0;
            s.phase = (octet != 8'd0) ? smsdd_pkg::PH_UDH : smsdd_pkg::PH_UCS2;
         end
         smsdd_pkg::PH_UDH: begin
            s.field_count = st.field_count + 8'd1;
            if (s.field_count == 8'd1 && octet != smsdd_pkg::IEI_CONCAT) s.concat_cand = 1'b0;
            if (s.field_count == 8'd2 && octet != smsdd_pkg::IEL_CONCAT) s.concat_cand = 1'b0;
            if (s.field_count == 8'd3) s.concat_ref = octet;
            if (s.field_count == 8'd4) s.concat_total = octet;
            if (s.field_count == 8'd5) s.concat_seq = octet;
            s.header_skip = st.header_skip - 8'd1;
            if (s.header_skip == 8'd0) s.phase = smsdd_pkg::PH_UCS2;
         end
         smsdd_pkg::PH_UCS2: begin
            if (!st.ucs2_half) begin
               s.ucs2_half = 1'b1;
               s.ucs2_high = octet;
            end else begin
               cp = {st.ucs2_high, octet};
               s.ucs2_half = 1'b0;
               s.ucs2_high = 8'd0;
               if (cp < 16'h0080) begin
                  r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_TEXT, cp[7:0]);
                  n = n + 3'd1;
               end else if (cp < 16'h0800) begin
                  r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_TEXT,
                                                smsdd_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]});
                  n = n + 3'd1;
                  r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_TEXT,
                                                smsdd_pkg::UTF8_CONT | {2'd0, cp[5:0]});
                  n = n + 3'd1;
               end else begin
                  r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_TEXT,
                                                smsdd_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]});
                  n = n + 3'd1;
                  r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_TEXT,
                     smsdd_pkg::UTF8_CONT | {2'd0, cp[11:6] & smsdd_pkg::UTF8_MASK});
                  n = n + 3'd1;
                  r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_TEXT,
                     smsdd_pkg::UTF8_CONT | {2'd0, cp[5:0] & smsdd_pkg::UTF8_MASK});
                  n = n + 3'd1;
               end
            end
         end
         smsdd_pkg::PH_GSM7: begin
            bbuf = st.bit_buffer | ({8'd0, octet} << st.bit_count[2:0]);
            bc = st.bit_count + 4'd8;
            for (int i = 0; i < 2; i++) begin
               if (bc >= 4'd7 && s.septets_left != 8'd0) begin
                  r[n[1:0]] = smsdd_pkg::mk_res(smsdd_pkg::KIND_TEXT,
                                                bbuf[7:0] & smsdd_pkg::SEPT_MASK);
                  n = n + 3'd1;
                  bbuf = bbuf >> 7;
                  bc = bc - 4'd7;
                  s.septets_left = s.septets_left - 8'd1;
               end
            end
            s.bit_buffer = bbuf;
            s.bit_count = bc;
            if (s.septets_left == 8'd0) s.phase = smsdd_pkg::PH_DONE;
         end
         default: begin
         end
      endcase

      if (last) begin
         err = (s.phase <= smsdd_pkg::PH_UDL) || (s.phase == smsdd_pkg::PH_UDHL) ||
               (s.phase == smsdd_pkg::PH_UDH) || (s.phase == smsdd_pkg::PH_GSM7);
         multi = s.concat_cand && (s.field_count >= smsdd_pkg::UDHL_CONCAT);
         sum = smsdd_pkg::mk_res(smsdd_pkg::KIND_END, 8'd0);
         sum.multipart = multi;
         sum.concat_ref = multi ? s.concat_ref : 8'd0;
         sum.concat_total = multi ? s.concat_total : 8'd0;
         sum.concat_seq = multi ? s.concat_seq : 8'd0;
         sum.error = err;
         sum.final_res = 1'b1;
         r[n[1:0]] = sum;
         n = n + 3'd1;
         s = '0;
      end

      st_in = s;
      batch.count = n;
      batch.res = r;
   end

endmodule

FILE: hw/rtl/smsdd_emit.sv
module smsdd_emit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  smsdd_pkg::batch_type  batch,
   input  logic                  rsp_tready,
   output logic                  free,
   output logic                  rsp_tvalid,
   output smsdd_pkg::result_type rsp_res
);

   localparam int unsigned CntW = $clog2(smsdd_pkg::MaxResults + 1);
   localparam int unsigned IdxW = $clog2(smsdd_pkg::MaxResults);

   smsdd_pkg::result_type [smsdd_pkg::MaxResults-1:0] res_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [IdxW-1:0] rd_ff, rd_in;
   logic            last_take;

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_res    = res_ff[rd_ff];
   assign last_take  = rsp_tvalid && rsp_tready && (CntW'(rd_ff) + CntW'(1) == count_ff);
   assign free       = (count_ff == '0) || last_take;

   always_comb begin
      count_in = count_ff;
      rd_in = rd_ff;
      if (load) begin
         count_in = batch.count;
         rd_in = '0;
      end else if (last_take) begin
         count_in = '0;
         rd_in = '0;
      end else if (rsp_tvalid && rsp_tready) begin
         rd_in = rd_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rd_ff <= '0;
      end else begin
         count_ff <= count_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= batch.res;
      end
   end

endmodule

FILE: hw/rtl/sms_deliver_pdu_decoder.sv
// SMS-DELIVER PDU decoder: octets enter on req_ (tlast on the final octet of the PDU) and
// results leave on rsp_, with the result kind on rsp_tuser and tlast on the end summary.
// An accepted octet sits in the input register, then is decoded in one pass into a batch
// of up to four results that is loaded into the result buffer and drained one result per
// cycle while rsp_tready is high. Octets that yield at most one result flow at one per
// cycle while rsp_tready is high; an octet yielding more results holds the input while the
// result buffer drains, so a UCS2 character with the end summary yields up to four results.
// After the end summary the decoder is back in its reset state, ready for the next PDU.
module sms_deliver_pdu_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // octet[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // value[7:0], multipart[8], concat_ref[16:9], concat_total[24:17], concat_seq[32:25],
   // error[33], zero fill[39:34]
   output logic [39:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,  // kind[1:0]
   output logic        rsp_tlast
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_octet_ff;
   logic                 in_last_ff;
   logic                 take;
   logic                 free;
   smsdd_pkg::state_type state_ff, state_in;
   smsdd_pkg::batch_type batch;
   smsdd_pkg::result_type res;

   assign take       = in_valid_ff && free;
   assign req_tready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (take) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_octet_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   smsdd_step u_step (
      .st    (state_ff),
      .octet (in_octet_ff),
      .last  (in_last_ff),
      .st_in (state_in),
      .batch (batch)
   );

   smsdd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .batch      (batch),
      .rsp_tready (rsp_tready),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_res    (res)
   );

   assign rsp_tdata = {6'd0, res.error, res.concat_seq, res.concat_total, res.concat_ref,
                       res.multipart, res.value};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.final_res;

endmodule

FILE: hw/rtl/smsdd_checker.sv
`include "assert_macros.svh"

module smsdd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   logic is_end;
   logic in_seen;

   assign is_end  = (rsp_tuser == smsdd_pkg::KIND_END);
   assign in_seen = req_tvalid && req_tready && (req_tdata != 8'd0 || req_tlast);

   `SMSDD_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")
   `SMSDD_ASSERT(a_plain_fields, clock, reset, rsp_tvalid && !is_end |-> rsp_tdata[39:8] == 32'd0 && !rsp_tlast, "summary fields set on a plain result")
   `SMSDD_ASSERT(a_end_shape, clock, reset, rsp_tvalid && is_end |-> rsp_tlast && rsp_tdata[7:0] == 8'd0 && (rsp_tdata[8] || rsp_tdata[32:9] == 24'd0), "malformed end summary")
   `SMSDD_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid, "result pending after reset")
   `SMSDD_ASSERT(a_no_early_out, clock, reset, $past(reset) && !in_seen |=> !rsp_tvalid, "result without a transaction")

endmodule

bind sms_deliver_pdu_decoder smsdd_checker u_smsdd_checker (.*);

FILE: bench/tb_sms_deliver_pdu_decoder.sv
module tb_sms_deliver_pdu_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 300000;

   typedef struct {
      logic [7:0] octet;
      logic       last;
   } pdu_octet_type;

   typedef logic [7:0] octet_list_type[$];

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   pdu_octet_type         octet_queue[$];
   smsdd_pkg::result_type decoded_queue[$];
   int         stall_pct    = 14;
   int         octets_built = 0;
   int         error_count  = 0;
   int         cycle_count  = 0;

   // decoder state
   smsdd_pkg::phase_type cur_phase = smsdd_pkg::PH_SMSC_LEN;
   logic [7:0] run_count    = 8'd0;
   logic       has_udh      = 1'b0;
   logic [7:0] addr_digits  = 8'd0;
   logic       is_ucs2      = 1'b0;
   logic [7:0] septets_due  = 8'd0;
   logic [7:0] udh_left     = 8'd0;
   logic       concat_seen  = 1'b0;
   logic [7:0] concat_id    = 8'd0;
   logic [7:0] concat_parts = 8'd0;
   logic [7:0] concat_part  = 8'd0;
   logic [15:0] sept_bits   = 16'd0;
   logic [3:0] sept_nbits   = 4'd0;
   logic       unit_pending = 1'b0;
   logic [7:0] unit_high    = 8'd0;

   sms_deliver_pdu_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %02h want %02h", name, got, want));
      end
   endtask

   function automatic void clear_decoder();
      cur_phase    = smsdd_pkg::PH_SMSC_LEN;
      run_count    = 8'd0;
      has_udh      = 1'b0;
      addr_digits  = 8'd0;
      is_ucs2      = 1'b0;
      septets_due  = 8'd0;
      udh_left     = 8'd0;
      concat_seen  = 1'b0;
      concat_id    = 8'd0;
      concat_parts = 8'd0;
      concat_part  = 8'd0;
      sept_bits    = 16'd0;
      sept_nbits   = 4'd0;
      unit_pending = 1'b0;
      unit_high    = 8'd0;
   endfunction

   function automatic void push_result(input smsdd_pkg::kind_type k, input logic [7:0] v);
      smsdd_pkg::result_type r;
      r = '0;
      r.kind = k;
      r.value = v;
      decoded_queue = {decoded_queue, r};
   endfunction

   function automatic void push_digit(input logic [3:0] nib);
      if (nib == smsdd_pkg::NIB_FILL || addr_digits == 8'd0) begin
         return;
      end
      addr_digits = addr_digits - 8'd1;
      push_result(smsdd_pkg::KIND_SENDER,
                  (nib < 4'd10) ? smsdd_pkg::CHAR_ZERO + {4'd0, nib}
                                : smsdd_pkg::CHAR_A + {4'd0, nib} - 8'd10);
   endfunction

   task automatic decode_pdu_octet(input logic [7:0] o, input logic is_last);
      logic [15:0] cp;
      logic        multi;
      smsdd_pkg::result_type r;
      case (cur_phase)
         smsdd_pkg::PH_SMSC_LEN: begin
            run_count = o;
            cur_phase = (o != 8'd0) ? smsdd_pkg::PH_SMSC_SKIP : smsdd_pkg::PH_FIRST;
         end
         smsdd_pkg::PH_SMSC_SKIP: begin
            run_count = run_count - 8'd1;
            if (run_count == 8'd0) cur_phase = smsdd_pkg::PH_FIRST;
         end
         smsdd_pkg::PH_FIRST: begin
            has_udh = (o & smsdd_pkg::UDHI_MASK) != 8'd0;
            cur_phase = smsdd_pkg::PH_ADDR_LEN;
         end
         smsdd_pkg::PH_ADDR_LEN: begin
            addr_digits = o;
            run_count = 8'(({1'b0, o} + 9'd1) >> 1);
            push_result(smsdd_pkg::KIND_SENDER, smsdd_pkg::CHAR_PLUS);
            cur_phase = smsdd_pkg::PH_TOA;
         end
         smsdd_pkg::PH_TOA:
            cur_phase = (run_count != 8'd0) ? smsdd_pkg::PH_ADDR : smsdd_pkg::PH_PID;
         smsdd_pkg::PH_ADDR: begin
            push_digit(o[3:0]);
            push_digit(o[7:4]);
            run_count = run_count - 8'd1;
            if (run_count == 8'd0) cur_phase = smsdd_pkg::PH_PID;
         end
         smsdd_pkg::PH_PID: cur_phase = smsdd_pkg::PH_DCS;
         smsdd_pkg::PH_DCS: begin
            is_ucs2 = (o == smsdd_pkg::DCS_UCS2);
            run_count = smsdd_pkg::TS_OCTETS;
            cur_phase = smsdd_pkg::PH_TS;
         end
         smsdd_pkg::PH_TS: begin
            push_result(smsdd_pkg::KIND_TIME, o);
            run_count = run_count - 8'd1;
            if (run_count == 8'd0) cur_phase = smsdd_pkg::PH_UDL;
         end
         smsdd_pkg::PH_UDL: begin
            septets_due = o;
            if (is_ucs2) begin
               cur_phase = has_udh ? smsdd_pkg::PH_UDHL : smsdd_pkg::PH_UCS2;
            end else begin
               cur_phase = (o != 8'd0) ? smsdd_pkg::PH_GSM7 : smsdd_pkg::PH_DONE;
            end
         end
         smsdd_pkg::PH_UDHL: begin
            udh_left = o;
            run_count = 8'd0;
            concat_seen = (o >= smsdd_pkg::UDHL_CONCAT);
            concat_id = 8'd0;
            concat_parts = 8'd0;
            concat_part = 8'd0;
            cur_phase = (o != 8'd0) ? smsdd_pkg::PH_UDH : smsdd_pkg::PH_UCS2;
         end
         smsdd_pkg::PH_UDH: begin
            run_count = run_count + 8'd1;
            if (run_count == 8'd1 && o != smsdd_pkg::IEI_CONCAT) concat_seen = 1'b0;
            if (run_count == 8'd2 && o != smsdd_pkg::IEL_CONCAT) concat_seen = 1'b0;
            if (run_count == 8'd3) concat_id = o;
            if (run_count == 8'd4) concat_parts = o;
            if (run_count == 8'd5) concat_part = o;
            udh_left = udh_left - 8'd1;
            if (udh_left == 8'd0) cur_phase = smsdd_pkg::PH_UCS2;
         end
         smsdd_pkg::PH_UCS2: begin
            if (!unit_pending) begin
               unit_pending = 1'b1;
               unit_high = o;
            end else begin
               cp = {unit_high, o};
               unit_pending = 1'b0;
               unit_high = 8'd0;
               if (cp < 16'h0080) begin
                  push_result(smsdd_pkg::KIND_TEXT, cp[7:0]);
               end else if (cp < 16'h0800) begin
                  push_result(smsdd_pkg::KIND_TEXT, smsdd_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]});
                  push_result(smsdd_pkg::KIND_TEXT,
                              smsdd_pkg::UTF8_CONT | {2'd0, cp[5:0] & smsdd_pkg::UTF8_MASK});
               end else begin
                  push_result(smsdd_pkg::KIND_TEXT, smsdd_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]});
                  push_result(smsdd_pkg::KIND_TEXT,
                              smsdd_pkg::UTF8_CONT | {2'd0, cp[11:6] & smsdd_pkg::UTF8_MASK});
                  push_result(smsdd_pkg::KIND_TEXT,
                              smsdd_pkg::UTF8_CONT | {2'd0, cp[5:0] & smsdd_pkg::UTF8_MASK});
               end
            end
         end
         smsdd_pkg::PH_GSM7: begin
            sept_bits = sept_bits | (16'(o) << sept_nbits[2:0]);
            sept_nbits = sept_nbits + 4'd8;
            while (sept_nbits >= 4'd7 && septets_due != 8'd0) begin
               push_result(smsdd_pkg::KIND_TEXT, sept_bits[7:0] & smsdd_pkg::SEPT_MASK);
               sept_bits = sept_bits >> 7;
               sept_nbits = sept_nbits - 4'd7;
               septets_due = septets_due - 8'd1;
            end
            if (septets_due == 8'd0) cur_phase = smsdd_pkg::PH_DONE;
         end
         default: ;
      endcase

      if (is_last) begin
         multi = concat_seen && run_count >= 8'd5;
         r = '0;
         r.kind = smsdd_pkg::KIND_END;
         r.multipart = multi;
         r.concat_ref = multi ? concat_id : 8'd0;
         r.concat_total = multi ? concat_parts : 8'd0;
         r.concat_seq = multi ? concat_part : 8'd0;
         r.error = (cur_phase <= smsdd_pkg::PH_UDL) || cur_phase == smsdd_pkg::PH_UDHL
                   || cur_phase == smsdd_pkg::PH_UDH || cur_phase == smsdd_pkg::PH_GSM7;
         r.final_res = 1'b1;
         decoded_queue = {decoded_queue, r};
         clear_decoder();
      end
   endtask

   // request driver
   always @(posedge clock) begin : drive_req
      pdu_octet_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'd0;
         req_tlast <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (octet_queue.size() != 0 && $urandom_range(99) >= stall_pct) begin
            item = octet_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= item.octet;
            req_tlast <= item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // transaction monitor on both channels
   always @(posedge clock) begin : watch
      smsdd_pkg::result_type got;
      smsdd_pkg::result_type want;
      if (reset) begin
         clear_decoder();
      end else begin
         if (req_tvalid && req_tready) begin
            decode_pdu_octet(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.kind = smsdd_pkg::kind_type'(rsp_tuser);
            got.value = rsp_tdata[7:0];
            got.multipart = rsp_tdata[8];
            got.concat_ref = rsp_tdata[16:9];
            got.concat_total = rsp_tdata[24:17];
            got.concat_seq = rsp_tdata[32:25];
            got.error = rsp_tdata[33];
            got.final_res = rsp_tlast;
            if (decoded_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction kind %0d value %02h",
                                         rsp_tuser, rsp_tdata[7:0]));
            end else begin
               want = decoded_queue.pop_front();
               check_field("kind", {6'd0, got.kind}, {6'd0, want.kind});
               check_field("value", got.value, want.value);
               check_field("multipart", {7'd0, got.multipart}, {7'd0, want.multipart});
               check_field("concat_ref", got.concat_ref, want.concat_ref);
               check_field("concat_total", got.concat_total, want.concat_total);
               check_field("concat_seq", got.concat_seq, want.concat_seq);
               check_field("error", {7'd0, got.error}, {7'd0, want.error});
               check_field("last", {7'd0, got.final_res}, {7'd0, want.final_res});
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_pdu(input octet_list_type body);
      pdu_octet_type item;
      foreach (body[i]) begin
         item.octet = body[i];
         item.last = (i == body.size() - 1);
         octet_queue = {octet_queue, item};
      end
      octets_built += body.size();
   endtask

   task automatic wait_drained();
      while (octet_queue.size() != 0 || req_tvalid || decoded_queue.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic build_random_pdu();
      octet_list_type b;
      int          mode;
      int          n;
      int          len;
      int          hl;
      logic        udhi;
      logic [7:0]  dcs;
      logic [15:0] unit;
      mode = $urandom_range(99);
      if (mode < 8) begin
         // line noise
         n = $urandom_range(1, 20);
         repeat (n) b = {b, 8'($urandom_range(255))};
      end else begin
         n = $urandom_range(0, 3);
         b = {b, 8'(n)};
         repeat (n) b = {b, 8'($urandom_range(255))};
         udhi = $urandom_range(1);
         b = {b, (8'($urandom_range(255)) & ~smsdd_pkg::UDHI_MASK)
                 | (udhi ? smsdd_pkg::UDHI_MASK : 8'd0)};
         len = ($urandom_range(99) < 3) ? $urandom_range(0, 255) : $urandom_range(0, 12);
         b = {b, 8'(len)};
         b = {b, 8'($urandom_range(255))};
         repeat ((len + 1) / 2) b = {b, 8'($urandom_range(255))};
         b = {b, 8'($urandom_range(255))};
         dcs = ($urandom_range(2) == 0) ? smsdd_pkg::DCS_UCS2 : 8'($urandom_range(255));
         b = {b, dcs};
         repeat (smsdd_pkg::TS_OCTETS) b = {b, 8'($urandom_range(255))};
         if (dcs == smsdd_pkg::DCS_UCS2) begin
            b = {b, 8'($urandom_range(255))};
            if (udhi) begin
               if ($urandom_range(99) < 60) begin
                  hl = $urandom_range(5, 9);
                  b = {b, 8'(hl)};
                  b = {b, smsdd_pkg::IEI_CONCAT};
                  b = {b, smsdd_pkg::IEL_CONCAT};
                  repeat (hl - 2) b = {b, 8'($urandom_range(255))};
               end else begin
                  hl = $urandom_range(0, 8);
                  b = {b, 8'(hl)};
                  repeat (hl) b = {b, 8'($urandom_range(3) == 0 ? 0 : $urandom_range(255))};
               end
            end
            n = $urandom_range(0, 6);
            repeat (n) begin
               case ($urandom_range(3))
                  0: unit = 16'($urandom_range(16'h007F));
                  1: unit = 16'($urandom_range(16'h0080, 16'h07FF));
                  2: unit = 16'($urandom_range(16'h0800, 16'hFFFF));
                  default: unit = 16'($urandom_range(16'hFFFF));
               endcase
               b = {b, unit[15:8]};
               b = {b, unit[7:0]};
            end
            if ($urandom_range(3) == 0) b = {b, 8'($urandom_range(255))};
         end else begin
            len = ($urandom_range(99) < 5) ? $urandom_range(0, 255) : $urandom_range(0, 40);
            b = {b, 8'(len)};
            repeat ((len * 7 + 7) / 8) b = {b, 8'($urandom_range(255))};
            if ($urandom_range(3) == 0) begin
               repeat ($urandom_range(1, 2)) b = {b, 8'($urandom_range(255))};
            end
         end
         // broken sequence: cut short
         if (mode < 22) begin
            n = $urandom_range(1, b.size() - 1);
            b = b[0:n-1];
         end
      end
      queue_pdu(b);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone octet: ends before any field
      queue_pdu('{8'hFF});
      // ucs2 with concatenation header, sender digits a to e with filler
      queue_pdu('{8'h00, 8'h44, 8'h05, 8'h91, 8'hBA, 8'hDC, 8'hFE, 8'h00, smsdd_pkg::DCS_UCS2,
                  8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'h0C,
                  8'h05, smsdd_pkg::IEI_CONCAT, smsdd_pkg::IEL_CONCAT, 8'hA5, 8'h02, 8'h01,
                  8'h07, 8'hFF, 8'hFF, 8'hFF, 8'h80});
      wait_drained();

      octets_built = 0;
      while (octets_built < 75) build_random_pdu();
      wait_drained();

      stall_pct = 0;
      octets_built = 0;
      while (octets_built < 75) build_random_pdu();
      wait_drained();

      stall_pct = 14;
      octets_built = 0;
      while (octets_built < 70) build_random_pdu();
      wait_drained();

      repeat (20) @(negedge clock);
      if (decoded_queue.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", decoded_queue.size()));
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/smsdd_pkg.sv
hw/rtl/smsdd_step.sv
hw/rtl/smsdd_emit.sv
hw/rtl/sms_deliver_pdu_decoder.sv
hw/rtl/smsdd_checker.sv
bench/tb_sms_deliver_pdu_decoder.sv
